### rtl/scpr_pkg.sv
package scpr_pkg;

	localparam int MAX_FRAMES = 64;
	localparam int PAGE_SHIFT = 10;
	localparam int ADDR_W     = 32;
	localparam int FRAME_W    = $clog2(MAX_FRAMES);
	localparam int COUNT_W    = FRAME_W + 1;
	localparam int PAGE_W     = ADDR_W - PAGE_SHIFT;
	localparam int TOTAL_W    = 32;
	localparam int PADDR_W    = 3;
	localparam int PDATA_W    = 32;

	localparam logic [PADDR_W-3:0] REG_FRAME_COUNT = '0;
	localparam logic [COUNT_W-1:0] FRAME_COUNT_RST = COUNT_W'(MAX_FRAMES);

	typedef logic [PAGE_W-1:0]  page_t;
	typedef logic [FRAME_W-1:0] frame_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef struct packed {
		logic  referenced;
		page_t page;
	} entry_t;

endpackage

### rtl/second_chance_page_replacement_unit.sv
// Second-chance (clock) page replacement unit. Each request carries a byte
// address; its page (address >> 10) is looked up among the resident frames.
// Every frame keeps its page number and reference bit in one single-port
// 64 x 23 synchronous RAM. The search reads the frames in use one frame per
// cycle and stops at a hit or after the last frame, so latency is data
// dependent. A hit in frame k ends the search at frame k; a miss with a free
// frame fills the next free frame, and while no frame is filled yet the
// search is skipped; a miss with all frames in use starts the clock hand,
// which reads and tests one frame at a time (SWEEP, then TEST) and clears
// each referenced frame until it finds an unreferenced victim. One request
// is in flight at a time; the response sits in an output register, and
// req_ready rises in the same cycle as rsp_valid, so the next request can be
// taken while the response waits. frame_count (register 0, reset 64, the
// low 7 bits of the written value) selects the frames in use; 0 acts as 1
// and values above 64 act as 64.
module second_chance_page_replacement_unit
	import scpr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [ADDR_W-1:0]   address,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic                fault,
	output logic [FRAME_W-1:0]  frame_index,
	output logic [TOTAL_W-1:0]  fault_total
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SEARCH = 3'd1;
	localparam logic [2:0] ST_MISS   = 3'd2;
	localparam logic [2:0] ST_SWEEP  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;
	localparam logic [2:0] ST_TEST   = 3'd5;

	logic [2:0]             state_q;
	count_t                 frame_count_q;
	count_t                 filled_q;
	frame_t                 hand_q;
	logic [TOTAL_W-1:0]     fault_cnt_q;
	page_t                  page_q;
	count_t                 n_q;
	count_t                 used_q;
	count_t                 rd_idx_q;
	frame_t                 slot_q;
	logic                   miss_q;
	logic                   chk_vld_s1;
	frame_t                 chk_idx_s1;
	entry_t                 rdata_s1;
	logic                   rsp_valid_q;
	logic                   fault_q;
	frame_t                 frame_index_q;
	logic [TOTAL_W-1:0]     fault_total_q;

	entry_t                 mem [MAX_FRAMES];

	logic                   cfg_wr;
	logic                   req_take;
	count_t                 n_in;
	count_t                 used_in;
	logic                   issue;
	logic                   match;
	logic                   last_chk;
	logic                   out_free;
	logic                   mem_we;
	logic                   mem_re;
	frame_t                 rd_addr;
	frame_t                 mem_waddr;
	entry_t                 mem_wdata;
	frame_t                 hand_next;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign prdata   = (paddr[PADDR_W-1:2] == REG_FRAME_COUNT) ?
		{{(PDATA_W-COUNT_W){1'b0}}, frame_count_q} : '0;

	assign req_ready = (state_q == ST_IDLE);
	assign req_take  = req_valid && req_ready;

	always_comb begin
		n_in = frame_count_q;
		if (frame_count_q == '0) begin
			n_in = count_t'(1);
		end else if (frame_count_q > count_t'(MAX_FRAMES)) begin
			n_in = count_t'(MAX_FRAMES);
		end
		used_in = (filled_q < n_in) ? filled_q : n_in;
	end

	assign match    = chk_vld_s1 && (rdata_s1.page == page_q);
	assign last_chk = chk_vld_s1 && ({1'b0, chk_idx_s1} == used_q - count_t'(1));
	assign issue    = (state_q == ST_SEARCH) && (rd_idx_q < used_q) && !match && !last_chk;
	assign out_free = !rsp_valid_q || rsp_ready;
	assign mem_re   = issue || (state_q == ST_SWEEP);
	assign rd_addr  = (state_q == ST_SWEEP) ? hand_q : rd_idx_q[FRAME_W-1:0];
	assign hand_next = ({1'b0, hand_q} + count_t'(1) == n_q) ? '0 : hand_q + frame_t'(1);

	// final write of the request, or reference clear during the sweep
	always_comb begin
		mem_we               = 1'b0;
		mem_waddr            = slot_q;
		mem_wdata.referenced = !miss_q;
		mem_wdata.page       = page_q;
		if ((state_q == ST_FINISH) && out_free) begin
			mem_we = 1'b1;
		end else if ((state_q == ST_TEST) && rdata_s1.referenced) begin
			mem_we               = 1'b1;
			mem_waddr            = hand_q;
			mem_wdata.referenced = 1'b0;
			mem_wdata.page       = rdata_s1.page;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_s1 <= mem[rd_addr];
		end
		chk_idx_s1 <= rd_idx_q[FRAME_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RST;
		end else if (cfg_wr && paddr[PADDR_W-1:2] == REG_FRAME_COUNT) begin
			frame_count_q <= pwdata[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			filled_q      <= '0;
			hand_q        <= '0;
			fault_cnt_q   <= '0;
			rd_idx_q      <= '0;
			chk_vld_s1    <= 1'b0;
			rsp_valid_q   <= 1'b0;
			miss_q        <= 1'b0;
			page_q        <= '0;
			n_q           <= '0;
			used_q        <= '0;
			slot_q        <= '0;
			fault_q       <= 1'b0;
			frame_index_q <= '0;
			fault_total_q <= '0;
		end else begin
			chk_vld_s1 <= issue;
			if (issue) begin
				rd_idx_q <= rd_idx_q + count_t'(1);
			end
			if ((state_q == ST_FINISH) && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						page_q   <= address[ADDR_W-1:PAGE_SHIFT];
						n_q      <= n_in;
						used_q   <= used_in;
						rd_idx_q <= '0;
						state_q  <= (used_in == '0) ? ST_MISS : ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (match) begin
						slot_q  <= chk_idx_s1;
						miss_q  <= 1'b0;
						state_q <= ST_FINISH;
					end else if (last_chk) begin
						state_q <= ST_MISS;
					end
				end
				ST_MISS: begin
					miss_q <= 1'b1;
					if (filled_q < n_q) begin
						slot_q   <= filled_q[FRAME_W-1:0];
						filled_q <= filled_q + count_t'(1);
						state_q  <= ST_FINISH;
					end else begin
						if ({1'b0, hand_q} >= n_q) begin
							hand_q <= '0;
						end
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					state_q <= ST_TEST;
				end
				ST_TEST: begin
					hand_q <= hand_next;
					if (rdata_s1.referenced) begin
						state_q <= ST_SWEEP;
					end else begin
						slot_q  <= hand_q;
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						fault_q       <= miss_q;
						frame_index_q <= slot_q;
						fault_total_q <= fault_cnt_q + TOTAL_W'(miss_q);
						fault_cnt_q   <= fault_cnt_q + TOTAL_W'(miss_q);
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign fault       = fault_q;
	assign frame_index = frame_index_q;
	assign fault_total = fault_total_q;

endmodule

### rtl/scpr_checker.sv
module scpr_checker
	import scpr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_ready,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  logic                fault,
	input  logic [FRAME_W-1:0]  frame_index,
	input  logic [TOTAL_W-1:0]  fault_total
);

	logic [TOTAL_W-1:0] last_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_total_q <= '0;
		end else if (rsp_valid && rsp_ready) begin
			last_total_q <= fault_total;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(fault) &&
			$stable(frame_index) && $stable(fault_total))
		else $error("response changed while stalled");

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready |-> fault_total == last_total_q + TOTAL_W'(fault))
		else $error("fault total does not follow fault flags");

	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while one is in flight");

	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("response appeared without a request in flight");

endmodule

bind second_chance_page_replacement_unit scpr_checker u_scpr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_ready   (req_ready),
	.rsp_valid   (rsp_valid),
	.rsp_ready   (rsp_ready),
	.fault       (fault),
	.frame_index (frame_index),
	.fault_total (fault_total)
);

### tb/sv/tb_second_chance_page_replacement_unit.sv
`timescale 1ns / 1ps

module tb_second_chance_page_replacement_unit;
	import scpr_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_REQUESTS = 75;
	localparam int PHASES = 12;
	localparam logic [PADDR_W-1:0] FRAME_COUNT_ADDR = {REG_FRAME_COUNT, 2'b00};
	localparam logic [PADDR_W-1:0] SPARE_REG_ADDR = 3'd4;

	typedef struct packed {
		logic               fault;
		frame_t             frame;
		logic [TOTAL_W-1:0] total;
	} page_result_t;

	class page_replacement_scoreboard;
		page_t              frame_page [MAX_FRAMES];
		bit                 ref_bit [MAX_FRAMES];
		int unsigned        filled;
		int unsigned        hand;
		logic [TOTAL_W-1:0] fault_count;
		count_t             frame_count;
		page_result_t       expected_q [$];
		int                 errors;
		int                 requests;
		int                 responses;
		int                 faults_seen;

		function new();
			foreach (frame_page[i]) begin
				frame_page[i] = '0;
				ref_bit[i] = 1'b0;
			end
			filled = 0;
			hand = 0;
			fault_count = '0;
			frame_count = FRAME_COUNT_RST;
			errors = 0;
			requests = 0;
			responses = 0;
			faults_seen = 0;
		endfunction

		function void set_frame_count(logic [PDATA_W-1:0] value);
			frame_count = value[COUNT_W-1:0];
		endfunction

		function int unsigned active_frames();
			if (frame_count == 0)
				return 1;
			if (frame_count > MAX_FRAMES)
				return MAX_FRAMES;
			return frame_count;
		endfunction

		function void note_request(logic [ADDR_W-1:0] addr);
			page_t        page;
			int unsigned  n;
			int unsigned  used;
			int unsigned  slot;
			int unsigned  h;
			bit           hit;
			page_result_t r;
			page = page_t'(addr >> PAGE_SHIFT);
			n = active_frames();
			used = (filled < n) ? filled : n;
			slot = 0;
			hit = 1'b0;
			for (int i = 0; i < used; i++) begin
				if (!hit && frame_page[i] == page) begin
					hit = 1'b1;
					slot = i;
				end
			end
			if (hit) begin
				ref_bit[slot] = 1'b1;
			end else begin
				if (filled < n) begin
					slot = filled;
					filled++;
				end else begin
					h = (hand >= n) ? 0 : hand;
					for (int k = 0; k < 2 * n; k++) begin
						if (!ref_bit[h])
							break;
						ref_bit[h] = 1'b0;
						h = (h + 1 == n) ? 0 : h + 1;
					end
					slot = h;
					hand = (h + 1 == n) ? 0 : h + 1;
				end
				frame_page[slot] = page;
				ref_bit[slot] = 1'b0;
				fault_count = fault_count + 1'b1;
			end
			r.fault = !hit;
			r.frame = frame_t'(slot);
			r.total = fault_count;
			expected_q = {expected_q, r};
			requests++;
		endfunction

		task report_mismatch(string msg);
			if (errors < 20)
				$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_response(logic f, frame_t idx, logic [TOTAL_W-1:0] total);
			page_result_t e;
			responses++;
			if (f === 1'b1)
				faults_seen++;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("response with no request pending (fault=%0b frame=%0d)",
					f, idx));
				return;
			end
			e = expected_q.pop_front();
			if (f !== e.fault)
				report_mismatch($sformatf("fault %0b, expected %0b", f, e.fault));
			if (idx !== e.frame)
				report_mismatch($sformatf("frame_index %0d, expected %0d", idx, e.frame));
			if (total !== e.total)
				report_mismatch($sformatf("fault_total %0d, expected %0d", total, e.total));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               req_valid;
	logic               req_ready;
	logic [ADDR_W-1:0]  address;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	logic               fault;
	frame_t             frame_index;
	logic [TOTAL_W-1:0] fault_total;

	page_replacement_scoreboard sb;
	int  cycles = 0;
	bit  sender_idles = 1'b0;
	bit  receiver_stalls = 1'b0;
	int  burst_left = 0;
	int  stall_left = 0;
	int  settings_used = 0;

	second_chance_page_replacement_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.address     (address),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.fault       (fault),
		.frame_index (frame_index),
		.fault_total (fault_total)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("** second_chance_page_replacement_unit: FAILED **");
			$finish;
		end
	end

	// receiver: always ready, or runs of stall cycles of random length when receiver_stalls is set
	always @(posedge clk) begin
		if (!receiver_stalls) begin
			rsp_ready <= 1'b1;
		end else if (stall_left > 0) begin
			rsp_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			rsp_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				stall_left <= $urandom_range(1, 20);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready)
			sb.check_response(fault, frame_index, fault_total);
	end

	task automatic send_request(input logic [ADDR_W-1:0] addr);
		int gap;
		if (sender_idles && burst_left == 0) begin
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		req_valid <= 1'b1;
		address <= addr;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		sb.note_request(addr);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic check_frame_count_read();
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= FRAME_COUNT_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== PDATA_W'(sb.frame_count))
			sb.report_mismatch($sformatf("frame_count reads %0d, expected %0d",
				prdata, sb.frame_count));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		wait_idle();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == FRAME_COUNT_ADDR) begin
			sb.set_frame_count(data);
			settings_used++;
		end
		check_frame_count_read();
	endtask

	initial begin
		logic [PDATA_W-1:0] phase_counts [PHASES];
		page_t              pool [];
		int unsigned        n;
		int                 pool_size;
		logic [ADDR_W-1:0]  addr;

		phase_counts = '{32'd64, 32'd1, 32'd2, 32'd5, 32'd16, 32'd33,
			32'h80, 32'hFFFF_FFFF, 32'd8, 32'd64, 32'd3, 32'd40};
		sb = new();
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		req_valid <= 1'b0;
		address <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_frame_count_read();

		// fills, hits within a page, lowest and highest page
		send_request(32'h0000_0000);
		send_request(32'hFFFF_FFFF);
		send_request(32'h0000_03FF);
		send_request(32'hFFFF_FC00);
		send_request(32'h0000_0400);
		// zero count acts as one frame, below the filled frames
		configure(FRAME_COUNT_ADDR, 32'd0);
		send_request(32'h1234_5678);
		send_request(32'hFFFF_FFFF);
		// oversize count saturates, write to an unused address is ignored
		configure(FRAME_COUNT_ADDR, 32'd127);
		configure(SPARE_REG_ADDR, 32'd5);
		send_request(32'hFFFF_FC01);
		send_request(32'h0000_0401);
		// move the hand round three frames, then shrink to two frames
		configure(FRAME_COUNT_ADDR, 32'd3);
		send_request(32'h1000_0000);
		send_request(32'h2000_0000);
		send_request(32'h0000_0000);
		configure(FRAME_COUNT_ADDR, 32'd2);
		send_request(32'h3000_0000);
		send_request(32'h3000_0155);

		for (int p = 0; p < PHASES; p++) begin
			configure(FRAME_COUNT_ADDR, phase_counts[p]);
			sender_idles = ($urandom_range(0, 2) != 0);
			receiver_stalls = ($urandom_range(0, 2) != 0);
			burst_left = 0;
			n = sb.active_frames();
			pool_size = n + $urandom_range(1, n + 1);
			pool = new[pool_size];
			foreach (pool[i])
				pool[i] = page_t'($urandom);
			for (int i = 0; i < PHASE_REQUESTS; i++) begin
				if ($urandom_range(0, 9) == 0)
					addr = $urandom;
				else
					addr = {pool[$urandom_range(0, pool_size - 1)], PAGE_SHIFT'($urandom)};
				send_request(addr);
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		$display("%0d requests, %0d responses checked, %0d page faults, %0d frame-count settings",
			sb.requests, sb.responses, sb.faults_seen, settings_used);
		$display("%0d leftover expectations, %0d mismatches", sb.expected_q.size(), sb.errors);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("** second_chance_page_replacement_unit: PASSED **");
		end else begin
			$display("** second_chance_page_replacement_unit: FAILED **");
		end
		$finish;
	end

endmodule

### files.f
rtl/scpr_pkg.sv
rtl/second_chance_page_replacement_unit.sv
rtl/scpr_checker.sv
tb/sv/tb_second_chance_page_replacement_unit.sv
